### design/write_batch_record_parser_macros.svh
// Assertion macros shared by the write batch record parser RTL.
`ifndef WRITE_BATCH_RECORD_PARSER_MACROS_SVH
`define WRITE_BATCH_RECORD_PARSER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WBRP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define WBRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wbrp_pkg.sv
// Shared types and codes of the write batch record parser.
package wbrp_pkg;

    // Parse phases; a byte's role code equals the phase it was parsed in.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TAG    = 3'd1,
        PH_KEYLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_VALLEN = 3'd4,
        PH_VALUE  = 3'd5,
        PH_COLUMN = 3'd6,
        PH_SKIP   = 3'd7
    } phase_t;

    // Byte roles.
    localparam logic [2:0] ROLE_HEADER = 3'd0;
    localparam logic [2:0] ROLE_TAG    = 3'd1;
    localparam logic [2:0] ROLE_KEYLEN = 3'd2;
    localparam logic [2:0] ROLE_KEY    = 3'd3;
    localparam logic [2:0] ROLE_VALLEN = 3'd4;
    localparam logic [2:0] ROLE_VALUE  = 3'd5;
    localparam logic [2:0] ROLE_COLUMN = 3'd6;
    localparam logic [2:0] ROLE_SKIP   = 3'd7;

    // Record kinds.
    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_MERGE  = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    // Batch status codes.
    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_TOO_SMALL   = 3'd1;
    localparam logic [2:0] STATUS_UNKNOWN_TAG = 3'd2;
    localparam logic [2:0] STATUS_TRUNCATED   = 3'd3;
    localparam logic [2:0] STATUS_MISMATCH    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_PUT_TAG    = 2'd0;
    localparam logic [1:0] REG_MERGE_TAG  = 2'd1;
    localparam logic [1:0] REG_DELETE_TAG = 2'd2;

    // Reset values of the tag registers.
    localparam logic [7:0] PUT_TAG_RESET    = 8'd1;
    localparam logic [7:0] MERGE_TAG_RESET  = 8'd2;
    localparam logic [7:0] DELETE_TAG_RESET = 8'd0;

    // Index of the last byte in the header and in a length field.
    localparam logic [1:0] LAST_FIELD_BYTE = 2'd3;

    typedef struct packed {
        logic [7:0] put_tag;
        logic [7:0] merge_tag;
        logic [7:0] delete_tag;
    } tags_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    // Handshake between the input stage and the rest of the pipeline.
    typedef struct packed {
        logic valid;
        logic fire;
    } stage_ctrl_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic [2:0]  byte_role;
        logic [1:0]  record_kind;
        logic        record_end;
        logic [15:0] column_id;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [31:0] records_found;
        logic        batch_end;
        logic [2:0]  status;
    } result_t;

endpackage

### design/wbrp_in_stage.sv
// Input register of the parser with its stall logic.
module wbrp_in_stage
    import wbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic        out_free,
    output stage_ctrl_t ctrl,
    output in_item_t    item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;
    logic     fire;

    // The held byte moves on whenever the result register can take it.
    assign fire     = valid_reg && out_free;
    assign in_stall = valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    // Valid tracking of the input register.
    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte <= data_byte;
            item_reg.last      <= last;
        end
    end

    assign ctrl.valid = valid_reg;
    assign ctrl.fire  = fire;
    assign item       = item_reg;

endmodule

### design/wbrp_parser.sv
// Field state machine that labels each batch byte and tracks lengths and status.
module wbrp_parser
    import wbrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  in_item_t item,
    input  tags_t    tags,
    output result_t  result
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  fidx_reg, fidx_next;
    logic [23:0] len_shift_reg, len_shift_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] header_reg, header_next;
    logic [31:0] found_reg, found_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] key_len_reg, key_len_next;
    logic [31:0] val_len_reg, val_len_next;
    logic [7:0]  col_lo_reg, col_lo_next;
    logic        unknown_reg, unknown_next;

    logic [7:0]  b;
    logic [31:0] full_len;
    logic [2:0]  role;
    logic        rec_end;
    logic [15:0] col;
    logic [2:0]  status;

    assign b        = item.data_byte;
    assign full_len = {b, len_shift_reg};

    // Next state and result fields for the byte in the input register.
    always_comb
    begin
        phase_next     = phase_reg;
        fidx_next      = fidx_reg;
        len_shift_next = len_shift_reg;
        remain_next    = remain_reg;
        header_next    = header_reg;
        found_next     = found_reg;
        kind_next      = kind_reg;
        key_len_next   = key_len_reg;
        val_len_next   = val_len_reg;
        col_lo_next    = col_lo_reg;
        unknown_next   = unknown_reg;
        role           = ROLE_SKIP;
        rec_end        = 1'b0;
        col            = 16'd0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                role        = ROLE_HEADER;
                header_next = header_reg | (32'(b) << {fidx_reg, 3'b000});
                if (fidx_reg == LAST_FIELD_BYTE)
                begin
                    fidx_next  = 2'd0;
                    phase_next = PH_TAG;
                end
                else
                begin
                    fidx_next = fidx_reg + 2'd1;
                end
            end
            PH_TAG:
            begin
                role         = ROLE_TAG;
                found_next   = found_reg + 32'd1;
                key_len_next = 32'd0;
                val_len_next = 32'd0;
                if (b == tags.put_tag || b == tags.merge_tag || b == tags.delete_tag)
                begin
                    // Put wins over merge, merge over delete when tags are equal.
                    if (b == tags.put_tag)
                    begin
                        kind_next = KIND_PUT;
                    end
                    else if (b == tags.merge_tag)
                    begin
                        kind_next = KIND_MERGE;
                    end
                    else
                    begin
                        kind_next = KIND_DELETE;
                    end
                    phase_next     = PH_KEYLEN;
                    fidx_next      = 2'd0;
                    len_shift_next = 24'd0;
                end
                else
                begin
                    unknown_next = 1'b1;
                    phase_next   = PH_SKIP;
                end
            end
            PH_KEYLEN:
            begin
                role = ROLE_KEYLEN;
                if (fidx_reg == LAST_FIELD_BYTE)
                begin
                    fidx_next      = 2'd0;
                    key_len_next   = full_len;
                    len_shift_next = 24'd0;
                    if (full_len != 32'd0)
                    begin
                        remain_next = full_len;
                        phase_next  = PH_KEY;
                    end
                    else if (kind_reg == KIND_DELETE)
                    begin
                        phase_next  = PH_COLUMN;
                        col_lo_next = 8'd0;
                    end
                    else
                    begin
                        phase_next = PH_VALLEN;
                    end
                end
                else
                begin
                    len_shift_next = len_shift_reg | (24'(b) << {fidx_reg, 3'b000});
                    fidx_next      = fidx_reg + 2'd1;
                end
            end
            PH_KEY:
            begin
                role        = ROLE_KEY;
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    fidx_next = 2'd0;
                    if (kind_reg == KIND_DELETE)
                    begin
                        phase_next  = PH_COLUMN;
                        col_lo_next = 8'd0;
                    end
                    else
                    begin
                        phase_next     = PH_VALLEN;
                        len_shift_next = 24'd0;
                    end
                end
            end
            PH_VALLEN:
            begin
                role = ROLE_VALLEN;
                if (fidx_reg == LAST_FIELD_BYTE)
                begin
                    fidx_next      = 2'd0;
                    val_len_next   = full_len;
                    len_shift_next = 24'd0;
                    if (full_len != 32'd0)
                    begin
                        remain_next = full_len;
                        phase_next  = PH_VALUE;
                    end
                    else
                    begin
                        phase_next  = PH_COLUMN;
                        col_lo_next = 8'd0;
                    end
                end
                else
                begin
                    len_shift_next = len_shift_reg | (24'(b) << {fidx_reg, 3'b000});
                    fidx_next      = fidx_reg + 2'd1;
                end
            end
            PH_VALUE:
            begin
                role        = ROLE_VALUE;
                remain_next = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    phase_next  = PH_COLUMN;
                    fidx_next   = 2'd0;
                    col_lo_next = 8'd0;
                end
            end
            PH_COLUMN:
            begin
                role = ROLE_COLUMN;
                if (fidx_reg == 2'd0)
                begin
                    col_lo_next = b;
                    fidx_next   = 2'd1;
                end
                else
                begin
                    rec_end    = 1'b1;
                    col        = {b, col_lo_reg};
                    fidx_next  = 2'd0;
                    phase_next = PH_TAG;
                end
            end
            PH_SKIP:
            begin
                role = ROLE_SKIP;
            end
            default:
            begin
                role = ROLE_SKIP;
            end
        endcase
    end

    // Final status of the batch, reported on the last byte only.
    always_comb
    begin
        status = STATUS_OK;
        if (item.last)
        begin
            if (unknown_next)
            begin
                status = STATUS_UNKNOWN_TAG;
            end
            else if (phase_next == PH_HEADER)
            begin
                status = STATUS_TOO_SMALL;
            end
            else if (phase_next != PH_TAG)
            begin
                status = STATUS_TRUNCATED;
            end
            else if (found_next != header_next)
            begin
                status = STATUS_MISMATCH;
            end
        end
    end

    // Parser state; the last byte of a batch returns everything to reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            fidx_reg      <= 2'd0;
            len_shift_reg <= 24'd0;
            remain_reg    <= 32'd0;
            header_reg    <= 32'd0;
            found_reg     <= 32'd0;
            kind_reg      <= KIND_PUT;
            key_len_reg   <= 32'd0;
            val_len_reg   <= 32'd0;
            col_lo_reg    <= 8'd0;
            unknown_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                phase_reg     <= PH_HEADER;
                fidx_reg      <= 2'd0;
                len_shift_reg <= 24'd0;
                remain_reg    <= 32'd0;
                header_reg    <= 32'd0;
                found_reg     <= 32'd0;
                kind_reg      <= KIND_PUT;
                key_len_reg   <= 32'd0;
                val_len_reg   <= 32'd0;
                col_lo_reg    <= 8'd0;
                unknown_reg   <= 1'b0;
            end
            else
            begin
                phase_reg     <= phase_next;
                fidx_reg      <= fidx_next;
                len_shift_reg <= len_shift_next;
                remain_reg    <= remain_next;
                header_reg    <= header_next;
                found_reg     <= found_next;
                kind_reg      <= kind_next;
                key_len_reg   <= key_len_next;
                val_len_reg   <= val_len_next;
                col_lo_reg    <= col_lo_next;
                unknown_reg   <= unknown_next;
            end
        end
    end

    // Result fields reflect the state after this byte.
    assign result.byte_out      = b;
    assign result.byte_role     = role;
    assign result.record_kind   = kind_next;
    assign result.record_end    = rec_end;
    assign result.column_id     = col;
    assign result.key_length    = key_len_next;
    assign result.value_length  = val_len_next;
    assign result.records_found = found_next;
    assign result.batch_end     = item.last;
    assign result.status        = status;

endmodule

### design/write_batch_record_parser.sv
// Top level of the write batch record parser: tag registers, pipeline and result register.
// Pipeline: a byte is accepted into the input register, then moves to the result register,
// and leaves when out_stall is low. Throughput: one byte per cycle while out_stall
// is low; output stalls hold the pipeline. The parse state machine updates once per byte.
// Reset: rst_n clears the pipeline valids and the parse state to the header phase,
// and loads the tag registers with put 1, merge 2 and delete 0.
`include "write_batch_record_parser_macros.svh"

module write_batch_record_parser
    import wbrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  byte_out,
    output logic [2:0]  byte_role,
    output logic [1:0]  record_kind,
    output logic        record_end,
    output logic [15:0] column_id,
    output logic [31:0] key_length,
    output logic [31:0] value_length,
    output logic [31:0] records_found,
    output logic        batch_end,
    output logic [2:0]  status
);

    tags_t       tags_reg;
    stage_ctrl_t s1_ctrl;
    in_item_t    s1_item;
    result_t     result;
    result_t     result_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        skip_end;

    // Tag registers; every configuration transaction is taken at once.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tags_reg.put_tag    <= PUT_TAG_RESET;
            tags_reg.merge_tag  <= MERGE_TAG_RESET;
            tags_reg.delete_tag <= DELETE_TAG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PUT_TAG:    tags_reg.put_tag    <= cfg_data;
                REG_MERGE_TAG:  tags_reg.merge_tag  <= cfg_data;
                REG_DELETE_TAG: tags_reg.delete_tag <= cfg_data;
                default:        tags_reg            <= tags_reg;
            endcase
        end
    end

    // The result register is free when empty or when its content leaves now.
    assign out_free = !out_valid_reg || !out_stall;

    wbrp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last      (last),
        .out_free  (out_free),
        .ctrl      (s1_ctrl),
        .item      (s1_item)
    );

    wbrp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_ctrl.fire),
        .item   (s1_item),
        .tags   (tags_reg),
        .result (result)
    );

    // Result register valid.
    always_comb
    begin
        if (s1_ctrl.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload capture.
    always_ff @(posedge clk)
    begin
        if (s1_ctrl.fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_out      = result_reg.byte_out;
    assign byte_role     = result_reg.byte_role;
    assign record_kind   = result_reg.record_kind;
    assign record_end    = result_reg.record_end;
    assign column_id     = result_reg.column_id;
    assign key_length    = result_reg.key_length;
    assign value_length  = result_reg.value_length;
    assign records_found = result_reg.records_found;
    assign batch_end     = result_reg.batch_end;
    assign status        = result_reg.status;

    // A valid last byte that was skipped.
    assign skip_end = out_valid_reg && batch_end && (byte_role == ROLE_SKIP);

    // Input stall only while the input register holds a byte.
    `WBRP_ASSERT_SAME(a_stall_needs_item, in_stall, s1_ctrl.valid, "stall without a held byte")
    // A byte that leaves the input register lands in the result register.
    `WBRP_ASSERT_NEXT(a_fire_fills_output, s1_ctrl.fire, out_valid_reg, "byte lost")
    // A skipped last byte can only follow an unknown tag.
    `WBRP_ASSERT_SAME(a_skip_status, skip_end, status == STATUS_UNKNOWN_TAG, "no tag error")

endmodule

### tb/tb_write_batch_record_parser.sv
// Self-checking testbench for the write batch record parser.
module tb_write_batch_record_parser;
    import wbrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_PUT_TAG;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  byte_out;
    logic [2:0]  byte_role;
    logic [1:0]  record_kind;
    logic        record_end;
    logic [15:0] column_id;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [31:0] records_found;
    logic        batch_end;
    logic [2:0]  status;

    write_batch_record_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_out     (byte_out),
        .byte_role    (byte_role),
        .record_kind  (record_kind),
        .record_end   (record_end),
        .column_id    (column_id),
        .key_length   (key_length),
        .value_length (value_length),
        .records_found(records_found),
        .batch_end    (batch_end),
        .status       (status)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Parser state as the testbench tracks it.
    tags_t       p_tags;
    phase_t      p_phase;
    logic [1:0]  p_index;
    logic [31:0] p_len_acc;
    logic [31:0] p_remaining;
    logic [31:0] p_header_count;
    logic [31:0] p_found;
    logic [1:0]  p_kind;
    logic [31:0] p_key_len;
    logic [31:0] p_val_len;
    logic [15:0] p_column;
    logic [2:0]  p_error;

    result_t     labelled_bytes[$];
    logic [7:0]  batch_bytes[$];
    int unsigned bytes_sent = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    // Appends one byte to the batch under construction.
    function automatic void append_batch_byte(input logic [7:0] v);
        batch_bytes = {batch_bytes, v};
    endfunction

    // Returns the parser to the header phase of a new batch.
    task automatic clear_batch_state();
        p_phase = PH_HEADER;
        p_index = '0;
        p_len_acc = '0;
        p_remaining = '0;
        p_header_count = '0;
        p_found = '0;
        p_kind = KIND_PUT;
        p_key_len = '0;
        p_val_len = '0;
        p_column = '0;
        p_error = STATUS_OK;
    endtask

    // After the key, a delete record goes to its column id, others to the value length.
    task automatic leave_key();
        if (p_kind == KIND_DELETE)
        begin
            p_phase = PH_COLUMN;
            p_index = '0;
            p_column = '0;
        end
        else
        begin
            p_phase = PH_VALLEN;
            p_index = '0;
            p_len_acc = '0;
        end
    endtask

    // Labels one accepted byte and queues the result that the parser must show for it.
    task automatic label_byte(input logic [7:0] b, input logic l);
        result_t     r;
        logic [31:0] b32;
        b32 = {24'd0, b};
        r = '0;
        r.byte_out = b;
        r.byte_role = ROLE_SKIP;
        case (p_phase)
            PH_HEADER:
            begin
                r.byte_role = ROLE_HEADER;
                p_header_count = p_header_count | (b32 << {p_index, 3'b000});
                if (p_index == LAST_FIELD_BYTE)
                begin
                    p_index = '0;
                    p_phase = PH_TAG;
                end
                else
                    p_index = p_index + 2'd1;
            end
            PH_TAG:
            begin
                r.byte_role = ROLE_TAG;
                p_found = p_found + 32'd1;
                p_key_len = '0;
                p_val_len = '0;
                if (b == p_tags.put_tag || b == p_tags.merge_tag || b == p_tags.delete_tag)
                begin
                    // Put wins over merge, merge over delete, when registers are equal.
                    if (b == p_tags.put_tag)
                        p_kind = KIND_PUT;
                    else if (b == p_tags.merge_tag)
                        p_kind = KIND_MERGE;
                    else
                        p_kind = KIND_DELETE;
                    p_phase = PH_KEYLEN;
                    p_index = '0;
                    p_len_acc = '0;
                end
                else
                begin
                    p_error = STATUS_UNKNOWN_TAG;
                    p_phase = PH_SKIP;
                end
            end
            PH_KEYLEN:
            begin
                r.byte_role = ROLE_KEYLEN;
                p_len_acc = p_len_acc | (b32 << {p_index, 3'b000});
                if (p_index == LAST_FIELD_BYTE)
                begin
                    p_index = '0;
                    p_key_len = p_len_acc;
                    p_len_acc = '0;
                    if (p_key_len != 0)
                    begin
                        p_remaining = p_key_len;
                        p_phase = PH_KEY;
                    end
                    else
                        leave_key();
                end
                else
                    p_index = p_index + 2'd1;
            end
            PH_KEY:
            begin
                r.byte_role = ROLE_KEY;
                p_remaining = p_remaining - 32'd1;
                if (p_remaining == 0)
                    leave_key();
            end
            PH_VALLEN:
            begin
                r.byte_role = ROLE_VALLEN;
                p_len_acc = p_len_acc | (b32 << {p_index, 3'b000});
                if (p_index == LAST_FIELD_BYTE)
                begin
                    p_index = '0;
                    p_val_len = p_len_acc;
                    p_len_acc = '0;
                    if (p_val_len != 0)
                    begin
                        p_remaining = p_val_len;
                        p_phase = PH_VALUE;
                    end
                    else
                    begin
                        p_phase = PH_COLUMN;
                        p_column = '0;
                    end
                end
                else
                    p_index = p_index + 2'd1;
            end
            PH_VALUE:
            begin
                r.byte_role = ROLE_VALUE;
                p_remaining = p_remaining - 32'd1;
                if (p_remaining == 0)
                begin
                    p_phase = PH_COLUMN;
                    p_index = '0;
                    p_column = '0;
                end
            end
            PH_COLUMN:
            begin
                r.byte_role = ROLE_COLUMN;
                if (p_index == 0)
                begin
                    p_column = {8'd0, b};
                    p_index = 2'd1;
                end
                else
                begin
                    p_column = {b, p_column[7:0]};
                    r.record_end = 1'b1;
                    r.column_id = p_column;
                    p_index = '0;
                    p_phase = PH_TAG;
                end
            end
            default:
                r.byte_role = ROLE_SKIP;
        endcase

        // Final status, by priority, on the byte that ends the batch.
        if (l)
        begin
            if (p_error == STATUS_UNKNOWN_TAG)
                r.status = STATUS_UNKNOWN_TAG;
            else if (p_phase == PH_HEADER)
                r.status = STATUS_TOO_SMALL;
            else if (p_phase != PH_TAG)
                r.status = STATUS_TRUNCATED;
            else if (p_found != p_header_count)
                r.status = STATUS_MISMATCH;
            else
                r.status = STATUS_OK;
        end

        r.record_kind = p_kind;
        r.key_length = p_key_len;
        r.value_length = p_val_len;
        r.records_found = p_found;
        r.batch_end = l;
        labelled_bytes = {labelled_bytes, r};
        if (l)
            clear_batch_state();
    endtask

    // Input gaps: mostly none or short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    // Sends one byte transaction and records its expected labels once accepted.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last <= l;
        do
            @(posedge clk);
        while (in_stall);
        label_byte(b, l);
        bytes_sent++;
    endtask

    // Waits until every expected result has arrived and the pipeline is empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (labelled_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write transaction; cfg_valid stays high for a following write.
    task automatic write_tag(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PUT_TAG:    p_tags.put_tag = value;
            REG_MERGE_TAG:  p_tags.merge_tag = value;
            REG_DELETE_TAG: p_tags.delete_tag = value;
            default: ;
        endcase
    endtask

    task automatic set_tags(input logic [7:0] put_v, input logic [7:0] merge_v,
                            input logic [7:0] delete_v);
        wait_drained();
        write_tag(REG_PUT_TAG, put_v);
        write_tag(REG_MERGE_TAG, merge_v);
        write_tag(REG_DELETE_TAG, delete_v);
        cfg_valid <= 1'b0;
    endtask

    // Batch building helpers.
    function automatic void add_u32(input logic [31:0] v);
        for (int i = 0; i < 4; i++)
            append_batch_byte(v[8*i +: 8]);
    endfunction

    function automatic logic [7:0] tag_for_kind(input logic [1:0] k);
        case (k)
            KIND_PUT:   return p_tags.put_tag;
            KIND_MERGE: return p_tags.merge_tag;
            default:    return p_tags.delete_tag;
        endcase
    endfunction

    function automatic logic [7:0] unknown_tag();
        logic [7:0] t;
        do
            t = 8'($urandom_range(0, 255));
        while (t == p_tags.put_tag || t == p_tags.merge_tag || t == p_tags.delete_tag);
        return t;
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 4);
        return $urandom_range(5, 24);
    endfunction

    // Appends a whole record; the value length is left out when the tag decodes to delete.
    function automatic void add_record(input logic [7:0] tag, input int unsigned klen,
                                       input int unsigned vlen, input logic [15:0] col);
        logic is_delete;
        is_delete = (tag != p_tags.put_tag) && (tag != p_tags.merge_tag)
                    && (tag == p_tags.delete_tag);
        append_batch_byte(tag);
        add_u32(klen);
        repeat (klen) append_batch_byte(8'($urandom_range(0, 255)));
        if (!is_delete)
        begin
            add_u32(vlen);
            repeat (vlen) append_batch_byte(8'($urandom_range(0, 255)));
        end
        append_batch_byte(col[7:0]);
        append_batch_byte(col[15:8]);
    endfunction

    // Sends the built batch with last on its final byte.
    task automatic flush_batch();
        for (int i = 0; i < batch_bytes.size(); i++)
            send_byte(batch_bytes[i], i == batch_bytes.size() - 1);
        batch_bytes.delete();
    endtask

    // Put, merge and delete records with empty and one-byte keys and values and mixed column ids.
    task automatic test_basic_records();
        add_u32(32'd3);
        add_record(p_tags.put_tag, 1, 0, 16'hFFFF);
        add_record(p_tags.merge_tag, 0, 1, 16'h0000);
        add_record(p_tags.delete_tag, 1, 0, 16'h5AA5);
        flush_batch();
    endtask

    // Short header, unknown tag with a skipped byte after it, and an empty batch.
    task automatic test_batch_status();
        append_batch_byte(8'hFF);
        append_batch_byte(8'h00);
        flush_batch();
        add_u32(32'd1);
        append_batch_byte(unknown_tag());
        append_batch_byte(8'hFF);
        flush_batch();
        add_u32(32'd0);
        flush_batch();
    endtask

    // All three tags equal: every record must decode as a put.
    task automatic test_tag_priority();
        set_tags(8'd7, 8'd7, 8'd7);
        add_u32(32'd1);
        add_record(8'd7, 0, 0, 16'h0102);
        flush_batch();
    endtask

    // Random batches: mostly well formed, with miscounted, truncated, bad-tag,
    // oversized-length and noise batches mixed in.
    task automatic run_random_batches(input int unsigned target);
        int unsigned start;
        int unsigned r;
        int unsigned n;
        int unsigned bad_at;
        logic [31:0] big;
        start = bytes_sent;
        while (bytes_sent - start < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                repeat ($urandom_range(1, 8)) append_batch_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 12)
            begin
                add_u32($urandom_range(1, 3));
                big = $urandom | 32'h8000_0000;
                if ($urandom_range(0, 1) == 1)
                begin
                    append_batch_byte(p_tags.put_tag);
                    add_u32(32'd0);
                    add_u32(big);
                end
                else
                begin
                    append_batch_byte(tag_for_kind(2'($urandom_range(0, 2))));
                    add_u32(big);
                end
                repeat ($urandom_range(1, 5)) append_batch_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                n = $urandom_range(0, 4);
                add_u32((r < 22) ? $urandom_range(0, 5) : n);
                bad_at = (r >= 22 && r < 34) ? $urandom_range(0, n) : n + 1;
                for (int i = 0; i <= n; i++)
                begin
                    if (i == bad_at)
                        add_record(unknown_tag(), pick_len(), pick_len(), 16'($urandom));
                    if (i < n)
                        add_record(tag_for_kind(2'($urandom_range(0, 2))), pick_len(),
                                   pick_len(), 16'($urandom));
                end
                // Cut the batch short so that last lands inside a field.
                if (r >= 34 && r < 48)
                    repeat ($urandom_range(1, batch_bytes.size() - 1)) batch_bytes.pop_back();
            end
            flush_batch();
        end
    endtask

    // Random traffic under several tag settings, one stretch with no idling.
    task automatic test_random_traffic();
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_tags(PUT_TAG_RESET, MERGE_TAG_RESET, DELETE_TAG_RESET);
                1: set_tags(8'hFF, 8'h00, 8'h80);
                2: set_tags(8'h00, 8'hFF, 8'h7F);
                4: set_tags(8'h3C, 8'hC3, 8'hC3);
                default: set_tags(8'($urandom_range(0, 84)), 8'($urandom_range(85, 169)),
                                  8'($urandom_range(170, 255)));
            endcase
            no_idle = (ph == 3);
            run_random_batches(90);
        end
        no_idle = 1'b0;
    endtask

    // Output stall: runs of random length, mostly short.
    initial
    begin
        int unsigned r;
        int unsigned n;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (no_idle || r < 55)
            begin
                out_stall <= 1'b0;
                n = $urandom_range(1, 4);
            end
            else
            begin
                out_stall <= 1'b1;
                n = (r < 85) ? $urandom_range(1, 2)
                  : (r < 95) ? $urandom_range(3, 8) : $urandom_range(15, 40);
            end
            repeat (n - 1) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (labelled_bytes.size() == 0)
            begin
                $display("%0t: unexpected result, byte_out %h", $time, byte_out);
                fail_count++;
            end
            else
            begin
                want = labelled_bytes.pop_front();
                check_field("byte_out", 32'(want.byte_out), 32'(byte_out));
                check_field("byte_role", 32'(want.byte_role), 32'(byte_role));
                check_field("record_kind", 32'(want.record_kind), 32'(record_kind));
                check_field("record_end", 32'(want.record_end), 32'(record_end));
                check_field("column_id", 32'(want.column_id), 32'(column_id));
                check_field("key_length", want.key_length, key_length);
                check_field("value_length", want.value_length, value_length);
                check_field("records_found", want.records_found, records_found);
                check_field("batch_end", 32'(want.batch_end), 32'(batch_end));
                check_field("status", 32'(want.status), 32'(status));
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     labelled_bytes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        p_tags = '{put_tag: PUT_TAG_RESET, merge_tag: MERGE_TAG_RESET,
                   delete_tag: DELETE_TAG_RESET};
        clear_batch_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_records();
        test_batch_status();
        test_tag_priority();
        test_random_traffic();

        wait_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
